>>> src/qss_pkg.sv
// Package for the quaternion slerp setup block: widths, constants, the
// arctangent table and the per-stage square root and CORDIC step functions.
// No dependencies.
package qss_pkg;

   localparam int COMP_W       = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 16;
   localparam int RAD_W        = 31;
   localparam int ROOT_W       = 32;
   localparam int CD_W         = 34;

   localparam logic [15:0] EPS_RESET   = 16'd33;
   localparam logic [15:0] ONE_Q15     = 16'd32768;
   localparam logic [15:0] HALF_PI_Q15 = 16'd51472;

   // atan(2^-i) in Q30.
   localparam logic [29:0] ATAN_Q30 [32] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic              flip;
      logic              linear;
      logic [15:0]       cosine;
      logic [RAD_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic                   flip;
      logic                   linear;
      logic [15:0]            sine;
      logic signed [CD_W-1:0] x;
      logic signed [CD_W-1:0] y;
      logic signed [CD_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic        flip;
      logic        linear;
      logic [15:0] theta;
      logic [15:0] sin_theta;
   } result_type;

   // One digit of the bit-pair square root; step k works on bit 2^(30-2k).
   function automatic sqrt_type sqrt_step(sqrt_type a, int unsigned k);
      sqrt_type          b;
      logic [ROOT_W-1:0] bitv;
      logic [ROOT_W-1:0] trial;
      b     = a;
      bitv  = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = a.root + bitv;
      if ({1'b0, a.rem} >= trial) begin
         b.rem  = RAD_W'({1'b0, a.rem} - trial);
         b.root = (a.root >> 1) + bitv;
      end else begin
         b.root = a.root >> 1;
      end
      return b;
   endfunction

   // One vectoring CORDIC rotation toward the x axis.
   function automatic cordic_type cordic_step(cordic_type a, int unsigned i);
      cordic_type             b;
      logic signed [CD_W-1:0] dx;
      logic signed [CD_W-1:0] dy;
      logic signed [CD_W-1:0] ang;
      b   = a;
      dx  = a.y >>> i;
      dy  = a.x >>> i;
      ang = signed'({{(CD_W-30){1'b0}}, ATAN_Q30[i]});
      if (!a.y[CD_W-1]) begin
         b.x = a.x + dx;
         b.y = a.y - dy;
         b.z = a.z + ang;
      end else begin
         b.x = a.x - dx;
         b.y = a.y + dy;
         b.z = a.z - ang;
      end
      return b;
   endfunction

endpackage

>>> src/qss_if.sv
// Handshake channel interfaces of the quaternion slerp setup block:
// input pair, result and configuration write. Depends on qss_pkg.
interface qss_req_if import qss_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type p_x;
   comp_type p_y;
   comp_type p_z;
   comp_type p_w;
   comp_type q_x;
   comp_type q_y;
   comp_type q_z;
   comp_type q_w;
   modport source (output valid, p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w, input ready);
   modport sink (input valid, p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w, output ready);
endinterface

interface qss_rsp_if;
   logic        valid;
   logic        ready;
   logic        flip;
   logic        linear;
   logic [15:0] theta;
   logic [15:0] sin_theta;
   modport source (output valid, flip, linear, theta, sin_theta, input ready);
   modport sink (input valid, flip, linear, theta, sin_theta, output ready);
endinterface

interface qss_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] linear_epsilon;
   modport source (output valid, linear_epsilon, input ready);
   modport sink (input valid, linear_epsilon, output ready);
endinterface

>>> src/quaternion_slerp_setup.sv
// Top level of the quaternion slerp setup block: dot product, cosine,
// square root and arccosine pipeline. Depends on qss_pkg and qss_if.
//
// Usage: each transfer on req_port carries two quaternions in signed Q1.15.
// Each one produces exactly one transfer on rsp_port with the flip and
// linear flags, theta (Q1.15 radians, 0 to pi/2) and sin(theta), both 0 if linear.
// csr_port writes linear_epsilon; it is always ready and should only be
// written while no item is in flight.
// Pipeline: an input transfer passes through four stages of dot product
// and cosine, 17 of the square root (the start remainder, then one root
// digit per stage), one stage that rounds the root, 16 of CORDIC (one
// rotation per stage), the final rounding stage and the output queue.
// Throughput: one item per cycle while the output queue has room; every
// stage advances together.
// Stalls: when the receiver holds rsp ready low, results collect in the
// output queue; once it holds two, the whole pipeline freezes and req ready
// drops, so nothing is lost or repeated. The queue count is a register,
// so req ready never depends combinationally on rsp ready.
// Reset clears all valid bits, empties the queue and sets linear_epsilon
// to 33 (about 0.001).
module quaternion_slerp_setup import qss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qss_req_if.sink   req_port,
   qss_rsp_if.source rsp_port,
   qss_csr_if.sink   csr_port
);

   localparam int SQ_BASE = 4;
   localparam int CD_BASE = SQ_BASE + SQRT_STEPS + 1;
   localparam int NSTAGE  = CD_BASE + CORDIC_STEPS + 2;

   logic [15:0] eps_ff;

   logic              adv;
   logic              accept;
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;

   comp_type             pv [4];
   comp_type             qv [4];
   logic signed [31:0]   prod_ff [4];
   logic signed [31:0]   prod_in [4];
   logic signed [33:0]   sum_ff;
   logic signed [33:0]   sum_in;
   logic                 flip3_ff;
   logic [32:0]          mag3_ff;
   logic [32:0]          mag3_in;
   logic                 flip4_ff;
   logic                 lin4_ff;
   logic [15:0]          cos4_ff;
   logic [15:0]          cos4_in;
   logic                 lin4_in;
   logic [33:0]          rnd4;
   logic [18:0]          craw4;

   sqrt_type   sq_ff [SQRT_STEPS+1];
   sqrt_type   sq_in [SQRT_STEPS+1];
   cordic_type cd_ff [CORDIC_STEPS+1];
   cordic_type cd_in [CORDIC_STEPS+1];
   logic [15:0] root_s;
   logic [15:0] sine_s;

   result_type             res_ff;
   result_type             res_in;
   logic signed [CD_W-1:0] zrnd;
   logic [CD_W-16:0]       tval;
   logic [15:0]            theta_s;

   result_type fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   // The pipeline moves as one while the output queue has room.
   assign adv    = !cnt_ff[1];
   assign accept = req_port.valid && adv;
   assign req_port.ready = adv;
   assign csr_port.ready = 1'b1;

   assign pv[0] = req_port.p_x;
   assign pv[1] = req_port.p_y;
   assign pv[2] = req_port.p_z;
   assign pv[3] = req_port.p_w;
   assign qv[0] = req_port.q_x;
   assign qv[1] = req_port.q_y;
   assign qv[2] = req_port.q_z;
   assign qv[3] = req_port.q_w;

   always_comb begin
      vld_in = {vld_ff[NSTAGE-2:0], accept};
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = pv[k] * qv[k];
      end
      sum_in = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      mag3_in = sum_ff[33] ? 33'(-sum_ff) : 33'(sum_ff);

      // Round half up from 30 to 15 fraction bits, then saturate at 1.0.
      rnd4  = {1'b0, mag3_ff} + 34'd16384;
      craw4 = rnd4[33:15];
      cos4_in = (craw4 > 19'(ONE_Q15)) ? ONE_Q15 : craw4[15:0];
      lin4_in = (17'(ONE_Q15) - 17'(cos4_in)) < 17'(eps_ff);

      sq_in[0].flip   = flip4_ff;
      sq_in[0].linear = lin4_ff;
      sq_in[0].cosine = cos4_ff;
      sq_in[0].rem    = RAD_W'(32'd1073741824 - 32'(cos4_ff) * 32'(cos4_ff));
      sq_in[0].root   = '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         sq_in[k+1] = sqrt_step(sq_ff[k], k);
      end

      // The final remainder is v - r*r; round the root to nearest.
      root_s = sq_ff[SQRT_STEPS].root[15:0];
      sine_s = (32'(sq_ff[SQRT_STEPS].rem) > sq_ff[SQRT_STEPS].root) ?
               16'(root_s + 16'd1) : root_s;
      cd_in[0].flip   = sq_ff[SQRT_STEPS].flip;
      cd_in[0].linear = sq_ff[SQRT_STEPS].linear;
      cd_in[0].sine   = sine_s;
      cd_in[0].x      = signed'(CD_W'({sq_ff[SQRT_STEPS].cosine, 15'd0}));
      cd_in[0].y      = signed'(CD_W'({sine_s, 15'd0}));
      cd_in[0].z      = '0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         cd_in[i+1] = cordic_step(cd_ff[i], i);
      end

      zrnd = cd_ff[CORDIC_STEPS].z + CD_W'(16384);
      tval = zrnd[CD_W-1:15];
      if (cd_ff[CORDIC_STEPS].z[CD_W-1]) begin
         theta_s = '0;
      end else if (tval > (CD_W-15)'(HALF_PI_Q15)) begin
         theta_s = HALF_PI_Q15;
      end else begin
         theta_s = tval[15:0];
      end
      res_in.flip      = cd_ff[CORDIC_STEPS].flip;
      res_in.linear    = cd_ff[CORDIC_STEPS].linear;
      res_in.theta     = cd_ff[CORDIC_STEPS].linear ? 16'd0 : theta_s;
      res_in.sin_theta = cd_ff[CORDIC_STEPS].linear ? 16'd0 : cd_ff[CORDIC_STEPS].sine;
   end

   assign push = adv && vld_ff[NSTAGE-1];
   assign pop  = rsp_port.valid && rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= EPS_RESET;
         vld_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (csr_port.valid) begin
            eps_ff <= csr_port.linear_epsilon;
         end
         if (adv) begin
            vld_ff <= vld_in;
         end
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         sum_ff   <= sum_in;
         flip3_ff <= sum_ff[33];
         mag3_ff  <= mag3_in;
         flip4_ff <= flip3_ff;
         lin4_ff  <= lin4_in;
         cos4_ff  <= cos4_in;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            cd_ff[i] <= cd_in[i];
         end
         res_ff <= res_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res_ff;
      end
   end

   assign rsp_port.valid     = cnt_ff != 2'd0;
   assign rsp_port.flip      = fifo_ff[rd_ptr_ff].flip;
   assign rsp_port.linear    = fifo_ff[rd_ptr_ff].linear;
   assign rsp_port.theta     = fifo_ff[rd_ptr_ff].theta;
   assign rsp_port.sin_theta = fifo_ff[rd_ptr_ff].sin_theta;

endmodule
